// ===== hdl/uartrb_pkg.sv =====
package uartrb_pkg;

  localparam int DEFAULT_DEPTH = 64;

  localparam logic [1:0] REQ_LINE_RX  = 2'd0;
  localparam logic [1:0] REQ_HOST_RD  = 2'd1;
  localparam logic [1:0] REQ_HOST_WR  = 2'd2;
  localparam logic [1:0] REQ_TX_READY = 2'd3;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_RX_OVFL   = 2'd1;
  localparam logic [1:0] ERR_RX_UNDFL  = 2'd2;
  localparam logic [1:0] ERR_TX_OVFL   = 2'd3;

  localparam logic [0:0] REG_BLOCKING_MODE = 1'd0;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] byte_in;
  } req_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       line_send;
    logic       accepted;
    logic [1:0] last_error;
    logic [5:0] rx_count;
    logic       tx_pending;
  } rsp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ring_stat_t;

  typedef struct packed {
    logic push;
    logic pop;
  } ring_ctl_t;

endpackage

// ===== hdl/uartrb_ring.sv =====
module uartrb_ring import uartrb_pkg::*; #(
  parameter int BUFFER_DEPTH = DEFAULT_DEPTH,
  localparam int PW = $clog2(BUFFER_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  ring_ctl_t     ctl,
  input  logic [7:0]    wdata,
  output ring_stat_t    stat,
  output logic [PW-1:0] count,
  output logic [7:0]    rdata
);

  logic [7:0]    store [BUFFER_DEPTH];
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [PW-1:0] head_inc;
  logic [PW-1:0] tail_inc;

  // pointers wrap on their own width: the depth is a power of two
  assign head_inc   = head + 1'b1;
  assign tail_inc   = tail + 1'b1;
  assign stat.full  = (head_inc == tail);
  assign stat.empty = (head == tail);
  assign count      = head - tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else begin
      if (ctl.push) begin
        head <= head_inc;
      end
      if (ctl.pop) begin
        tail <= tail_inc;
      end
    end
  end

  // pre-increment: store at the advanced head, load from the advanced tail
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      store[head_inc] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      rdata <= store[tail_inc];
    end
  end

endmodule

// ===== hdl/uart_rx_tx_ring_buffers_top.sv =====
// UART receive/transmit ring buffers between a serial line and a host.
// Request channel (req_valid/req_stall/req): one event per item, either a
// byte from the line, a host read, a host write or a transmitter-ready event.
// Response channel (rsp_valid/rsp_stall/rsp): exactly one result per item,
// in order, carrying the byte read or sent, status, last error, receive
// count and the transmit-pending flag.
// The event is decided and the buffer memory read at the accepting edge, and
// the result register loads from the memory-read stage when the output does
// not stall. Throughput is one item per cycle when there is no stall, set by
// the single pass through the pointer compare and a read and a write port per
// buffer. When the consumer stalls, the result register holds and one more
// item may sit in the memory-read stage; after that req_stall rises until the
// result is taken. Reset clears both buffers to empty, the error to none,
// send-enable to 0 and blocking_mode to 1; memory contents are not cleared
// and need not be. The user must write blocking_mode over the APB port at
// address 0 only while idle; the block itself does not enforce this.
module uart_rx_tx_ring_buffers_top import uartrb_pkg::*; #(
  parameter int BUFFER_DEPTH = DEFAULT_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PW = $clog2(BUFFER_DEPTH);

  logic          blocking_mode;
  logic [1:0]    error_code;
  logic [1:0]    error_code_next;
  logic          send_enable;
  logic          send_enable_next;

  ring_ctl_t     rx_ctl;
  ring_ctl_t     tx_ctl;
  ring_stat_t    rx_stat;
  ring_stat_t    tx_stat;
  logic [PW-1:0] rx_cnt;
  logic [PW-1:0] tx_cnt;
  logic [PW-1:0] rx_cnt_next;
  logic [7:0]    rx_rdata;
  logic [7:0]    tx_rdata;

  logic          take;
  logic          line_send;
  logic          accepted;

  // memory-read stage
  logic          s1_valid;
  logic          s1_rx_rd;
  logic          s1_tx_rd;
  rsp_t          s1;
  logic          s1_adv;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BLOCKING_MODE) ? {31'd0, blocking_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      blocking_mode <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == REG_BLOCKING_MODE) begin
      blocking_mode <= pwdata[0];
    end
  end

  assign s1_adv    = !rsp_valid || !rsp_stall;
  assign req_stall = s1_valid && !s1_adv;
  assign take      = req_valid && !req_stall;

  always_comb begin
    rx_ctl           = '0;
    tx_ctl           = '0;
    line_send        = 1'b0;
    accepted         = 1'b0;
    error_code_next  = error_code;
    send_enable_next = send_enable;
    unique case (req.req_type)
      REQ_LINE_RX: begin
        if (rx_stat.full) begin
          error_code_next = ERR_RX_OVFL;
        end else begin
          rx_ctl.push = take;
          accepted    = 1'b1;
        end
      end
      REQ_HOST_RD: begin
        if (rx_stat.empty) begin
          error_code_next = ERR_RX_UNDFL;
        end else begin
          error_code_next = ERR_NONE;
          rx_ctl.pop      = take;
          accepted        = 1'b1;
        end
      end
      REQ_HOST_WR: begin
        if (tx_stat.full) begin
          // blocking: refuse for retry and keep the error as it is
          if (!blocking_mode) begin
            error_code_next = ERR_TX_OVFL;
          end
        end else begin
          tx_ctl.push      = take;
          send_enable_next = 1'b1;
          error_code_next  = ERR_NONE;
          accepted         = 1'b1;
        end
      end
      REQ_TX_READY: begin
        if (send_enable) begin
          if (tx_stat.empty) begin
            send_enable_next = 1'b0;
          end else begin
            tx_ctl.pop = take;
            line_send  = 1'b1;
            accepted   = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rx_cnt_next = rx_cnt;
    if (rx_ctl.push) begin
      rx_cnt_next = rx_cnt + 1'b1;
    end else if (rx_ctl.pop) begin
      rx_cnt_next = rx_cnt - 1'b1;
    end
  end

  uartrb_ring #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_rx_ring (
    .clk   (clk),
    .rst   (rst),
    .ctl   (rx_ctl),
    .wdata (req.byte_in),
    .stat  (rx_stat),
    .count (rx_cnt),
    .rdata (rx_rdata)
  );

  uartrb_ring #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_tx_ring (
    .clk   (clk),
    .rst   (rst),
    .ctl   (tx_ctl),
    .wdata (req.byte_in),
    .stat  (tx_stat),
    .count (tx_cnt),
    .rdata (tx_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      error_code  <= ERR_NONE;
      send_enable <= 1'b0;
    end else if (take) begin
      error_code  <= error_code_next;
      send_enable <= send_enable_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // byte_out is filled from the memory read data on the way out for reads, else 0
  always_ff @(posedge clk) begin
    if (take) begin
      s1_rx_rd      <= rx_ctl.pop;
      s1_tx_rd      <= tx_ctl.pop;
      s1.byte_out   <= 8'd0;
      s1.line_send  <= line_send;
      s1.accepted   <= accepted;
      s1.last_error <= error_code_next;
      s1.rx_count   <= 6'(rx_cnt_next);
      s1.tx_pending <= send_enable_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      rsp.line_send  <= s1.line_send;
      rsp.accepted   <= s1.accepted;
      rsp.last_error <= s1.last_error;
      rsp.rx_count   <= s1.rx_count;
      rsp.tx_pending <= s1.tx_pending;
      if (s1_rx_rd) begin
        rsp.byte_out <= rx_rdata;
      end else if (s1_tx_rd) begin
        rsp.byte_out <= tx_rdata;
      end else begin
        rsp.byte_out <= s1.byte_out;
      end
    end
  end

  // transmit fill level is not used by this block
  logic tx_cnt_unused;
  assign tx_cnt_unused = ^tx_cnt;

endmodule

// ===== hdl/uartrb_checker.sv =====
module uartrb_checker import uartrb_pkg::*; (
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // no result may appear on the edge right after reset
  a_reset_quiet: assert property (@(posedge clk) $fell(rst) |-> !rsp_valid)
    else $error("result valid right after reset");

  a_send_is_accepted: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.line_send |-> rsp.accepted)
    else $error("line byte sent on a refused item");

  a_refused_no_byte: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.accepted |-> rsp.byte_out == 8'd0 && !rsp.line_send)
    else $error("byte on a refused or empty item");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

endmodule

bind uart_rx_tx_ring_buffers_top uartrb_checker u_uartrb_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
